### rtl/core/ppg_waveform_conditioner_unit_assert.svh
// assertion macros for the ppg waveform conditioner checker
// no dependencies; included by the checker file
`ifndef PPG_WAVEFORM_CONDITIONER_UNIT_ASSERT_SVH
`define PPG_WAVEFORM_CONDITIONER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPG_WC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPG_WC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ppg_wc_pkg.sv
// shared types, widths and constants of the ppg waveform conditioner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppg_wc_pkg;

  localparam int IR_W      = 18;
  localparam int PT_W      = 19;
  localparam int ENV_W     = 18;
  localparam int SUM_W     = 28;
  localparam int SCNT_W    = 8;
  localparam int PH_W      = 8;
  localparam int ROW_W     = 6;
  localparam int HH_W      = 5;
  localparam int SH_W      = 4;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 8;
  localparam int PROD_W    = PT_W + HH_W;
  localparam int DVD_W     = SUM_W;
  localparam int DVS_W     = ENV_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 18;

  localparam int POINTS_DEF      = 128;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int WAVE_TOP_DEF    = 16;
  localparam int WAVE_BOTTOM_DEF = 63;

  localparam logic [SH_W-1:0]  BSHIFT_RST = 4'd6;
  localparam logic [PH_W-1:0]  PSTEP_RST  = 8'd40;
  localparam logic [PH_W-1:0]  PWRAP_RST  = 8'd100;
  localparam logic [ENV_W-1:0] MINSC_RST  = 18'd300;
  localparam logic [SH_W-1:0]  DSHIFT_RST = 4'd6;
  localparam logic [ROW_W-1:0] CENTER_RST = 6'd40;
  localparam logic [HH_W-1:0]  HH_RST     = 5'd21;

  localparam logic [SCNT_W-1:0] SUM_CNT_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_SHIFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_WRAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCALE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SHIFT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_CENTER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_ACC,
    ST_PSTART,
    ST_PWAIT,
    ST_PUSH,
    ST_RADDR,
    ST_RDATA,
    ST_RSTART,
    ST_RWAIT,
    ST_RROW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/ppg_wc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ppg_wc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppg_wc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ppg_wc_pkg::DVD_W-1:0] dividend,
  input  wire logic [ppg_wc_pkg::DVS_W-1:0] divisor,
  output logic      [ppg_wc_pkg::DVD_W-1:0] quotient,
  output ppg_wc_pkg::div_stat_t             stat
);

  localparam int DW  = ppg_wc_pkg::DVD_W;
  localparam int SW  = ppg_wc_pkg::DVS_W;
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   trial;
  logic [SW:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### rtl/core/ppg_wc_hist.sv
// history ring memory, one write port and one registered read port
// depends on ppg_wc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppg_wc_hist #(
  parameter int POINTS = ppg_wc_pkg::POINTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic        [$clog2(POINTS)-1:0]   wr_addr,
  input  wire logic signed [ppg_wc_pkg::PT_W-1:0] wr_data,
  input  wire logic        [$clog2(POINTS)-1:0]   rd_addr,
  output logic signed      [ppg_wc_pkg::PT_W-1:0] rd_data
);

  logic signed [ppg_wc_pkg::PT_W-1:0] mem [POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/ppg_waveform_conditioner_unit.sv
// ppg waveform conditioner top level: sequencer, state registers and output register
// depends on ppg_wc_pkg, ppg_wc_div, ppg_wc_hist
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  cmd, ir_sample, finger_on, position
// out      output     out_valid / out_stall point_ready, ac_point, envelope, stored_count,
//                                          history_reset, pixel_row, read_ok
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// one item at a time; in_stall is high from acceptance until the result is registered
// sample without a point: baseline and accumulate steps; finger change: straight to the done state
// sample with a point or a valid read: also runs the 28-step serial divider
// the result waits in the output register while out_stall is high; the next item is
// taken meanwhile and finishes once that register is free
// synchronous active-low reset; the history memory needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ppg_waveform_conditioner_unit #(
  parameter int POINTS      = ppg_wc_pkg::POINTS_DEF,
  parameter int FRAC_BITS   = ppg_wc_pkg::FRAC_BITS_DEF,
  parameter int WAVE_TOP    = ppg_wc_pkg::WAVE_TOP_DEF,
  parameter int WAVE_BOTTOM = ppg_wc_pkg::WAVE_BOTTOM_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    in_cmd,
  input  wire logic        [ppg_wc_pkg::IR_W-1:0]      in_ir_sample,
  input  wire logic                                    in_finger_on,
  input  wire logic        [ppg_wc_pkg::POS_W-1:0]     in_position,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic                                         out_point_ready,
  output logic signed      [ppg_wc_pkg::PT_W-1:0]      out_ac_point,
  output logic             [ppg_wc_pkg::ENV_W-1:0]     out_envelope,
  output logic             [ppg_wc_pkg::CNT_OUT_W-1:0] out_stored_count,
  output logic                                         out_history_reset,
  output logic             [ppg_wc_pkg::ROW_W-1:0]     out_pixel_row,
  output logic                                         out_read_ok,
  input  wire logic                                    cfg_we,
  input  wire logic        [ppg_wc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [ppg_wc_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IR_W   = ppg_wc_pkg::IR_W;
  localparam int PT_W   = ppg_wc_pkg::PT_W;
  localparam int ENV_W  = ppg_wc_pkg::ENV_W;
  localparam int SUM_W  = ppg_wc_pkg::SUM_W;
  localparam int SCNT_W = ppg_wc_pkg::SCNT_W;
  localparam int PH_W   = ppg_wc_pkg::PH_W;
  localparam int ROW_W  = ppg_wc_pkg::ROW_W;
  localparam int HH_W   = ppg_wc_pkg::HH_W;
  localparam int SH_W   = ppg_wc_pkg::SH_W;
  localparam int POS_W  = ppg_wc_pkg::POS_W;
  localparam int PROD_W = ppg_wc_pkg::PROD_W;
  localparam int DVD_W  = ppg_wc_pkg::DVD_W;
  localparam int DVS_W  = ppg_wc_pkg::DVS_W;
  localparam int OCW    = ppg_wc_pkg::CNT_OUT_W;

  localparam int IDX_W  = $clog2(POINTS);
  localparam int VCNT_W = $clog2(POINTS + 1);
  localparam int CMP_W  = ((VCNT_W > POS_W) ? VCNT_W : POS_W) + 1;
  localparam int BASE_W = IR_W + FRAC_BITS;

  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(POINTS - 1);
  localparam logic [VCNT_W-1:0]    FULL_CNT = VCNT_W'(POINTS);
  localparam logic [CMP_W-1:0]     PTS_CMP  = CMP_W'(POINTS);
  localparam logic signed [8:0]    ROW_LO   = 9'(WAVE_TOP + 1);
  localparam logic signed [8:0]    ROW_HI   = 9'(WAVE_BOTTOM - 1);

  // configuration
  logic [SH_W-1:0]  bshift_r;
  logic [PH_W-1:0]  pstep_r;
  logic [PH_W-1:0]  pwrap_r;
  logic [ENV_W-1:0] minsc_r;
  logic [SH_W-1:0]  dshift_r;
  logic [ROW_W-1:0] center_r;
  logic [HH_W-1:0]  hh_r;

  // block state
  ppg_wc_pkg::state_t       state_r, state_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [IDX_W-1:0]         wp_r, wp_nxt;
  logic [VCNT_W-1:0]        vcnt_r, vcnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SCNT_W-1:0]        scnt_r, scnt_nxt;
  logic [PH_W-1:0]          phase_r, phase_nxt;
  logic [ENV_W-1:0]         env_r, env_nxt;
  logic                     track_r, track_nxt;

  // item and work registers
  logic                     cmd_r, cmd_nxt;
  logic [IR_W-1:0]          ir_r, ir_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     neg_r, neg_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;

  // result staging
  logic                     rdy_r, rdy_nxt;
  logic signed [PT_W-1:0]   point_r, point_nxt;
  logic                     hrst_r, hrst_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic                     ok_r, ok_nxt;

  // output register
  logic                     ovalid_r, ovalid_nxt;
  logic                     out_load;

  // shared datapath signals
  logic                     accept;
  logic [BASE_W-1:0]        irq;
  logic signed [BASE_W:0]   bdiff;
  logic signed [BASE_W:0]   bsum;
  logic [IR_W-1:0]          base_hi;
  logic signed [PT_W-1:0]   ac;
  logic signed [SUM_W-1:0]  sum_new;
  logic [SCNT_W-1:0]        scnt_new;
  logic [PH_W-1:0]          ph_add;
  logic                     ph_wrap;
  logic                     acc_emit;
  logic [DVD_W-1:0]         abs_sum;
  logic [ENV_W-1:0]         row_div;
  logic [CMP_W-1:0]         pos_ext;
  logic                     pos_ok;
  logic [CMP_W-1:0]         old_sum;
  logic [CMP_W-1:0]         oldest;
  logic [CMP_W-1:0]         idx_sum;
  logic [CMP_W-1:0]         idx_w;
  logic [PT_W-1:0]          rd_mag;
  logic [PT_W-1:0]          qmag;
  logic signed [PT_W-1:0]   pt_val;
  logic [ENV_W-1:0]         dec;
  logic [HH_W-1:0]          s_clip;
  logic signed [8:0]        yv;
  logic signed [8:0]        y_clip;

  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic [DVS_W-1:0]         div_dvs;
  logic [DVD_W-1:0]         div_q;
  ppg_wc_pkg::div_stat_t    div_stat;

  logic                     mem_we;
  logic signed [PT_W-1:0]   mem_rd;

  assign in_stall = (state_r != ppg_wc_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == ppg_wc_pkg::ST_DONE) && (!ovalid_r || !out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bshift_r <= ppg_wc_pkg::BSHIFT_RST;
      pstep_r  <= ppg_wc_pkg::PSTEP_RST;
      pwrap_r  <= ppg_wc_pkg::PWRAP_RST;
      minsc_r  <= ppg_wc_pkg::MINSC_RST;
      dshift_r <= ppg_wc_pkg::DSHIFT_RST;
      center_r <= ppg_wc_pkg::CENTER_RST;
      hh_r     <= ppg_wc_pkg::HH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppg_wc_pkg::CFG_BASELINE_SHIFT: bshift_r <= cfg_wdata[SH_W-1:0];
        ppg_wc_pkg::CFG_PHASE_STEP:     pstep_r  <= cfg_wdata[PH_W-1:0];
        ppg_wc_pkg::CFG_PHASE_WRAP:     pwrap_r  <= cfg_wdata[PH_W-1:0];
        ppg_wc_pkg::CFG_MIN_SCALE:      minsc_r  <= cfg_wdata[ENV_W-1:0];
        ppg_wc_pkg::CFG_DECAY_SHIFT:    dshift_r <= cfg_wdata[SH_W-1:0];
        ppg_wc_pkg::CFG_WAVE_CENTER:    center_r <= cfg_wdata[ROW_W-1:0];
        ppg_wc_pkg::CFG_HALF_HEIGHT:    hh_r     <= cfg_wdata[HH_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic shared by both combinational blocks
  always_comb begin
    irq      = BASE_W'(ir_r) << FRAC_BITS;
    bdiff    = $signed({1'b0, irq}) - $signed({1'b0, base_r});
    bsum     = $signed({1'b0, base_r}) + (bdiff >>> bshift_r);
    base_hi  = IR_W'(base_r >> FRAC_BITS);
    ac       = $signed({1'b0, ir_r}) - $signed({1'b0, base_hi});
    sum_new  = sum_r + SUM_W'(ac);
    scnt_new = scnt_r + SCNT_W'(1);
    ph_add   = phase_r + pstep_r;
    ph_wrap  = (ph_add >= pwrap_r);
    acc_emit = ph_wrap || (scnt_new >= ppg_wc_pkg::SUM_CNT_MAX);
    abs_sum  = sum_r[SUM_W-1] ? DVD_W'(-sum_r) : DVD_W'(sum_r);
    row_div  = (env_r >= minsc_r) ? env_r : minsc_r;
    if (row_div == '0) begin
      row_div = ENV_W'(1);
    end
    pos_ext  = CMP_W'(pos_r);
    pos_ok   = (pos_ext < CMP_W'(vcnt_r));
    old_sum  = CMP_W'(wp_r) + PTS_CMP - CMP_W'(vcnt_r);
    oldest   = (old_sum >= PTS_CMP) ? old_sum - PTS_CMP : old_sum;
    idx_sum  = oldest + pos_ext;
    idx_w    = (idx_sum >= PTS_CMP) ? idx_sum - PTS_CMP : idx_sum;
    rd_mag   = mem_rd[PT_W-1] ? PT_W'(-mem_rd) : PT_W'(mem_rd);
    qmag     = div_q[PT_W-1:0];
    pt_val   = neg_r ? -$signed(qmag) : $signed(qmag);
    dec      = (env_r - minsc_r) >> dshift_r;
    s_clip   = (div_q > DVD_W'(hh_r)) ? hh_r : div_q[HH_W-1:0];
    yv       = neg_r ? $signed({3'b000, center_r}) + $signed({4'b0000, s_clip})
                     : $signed({3'b000, center_r}) - $signed({4'b0000, s_clip});
    y_clip   = (yv < ROW_LO) ? ROW_LO : ((yv > ROW_HI) ? ROW_HI : yv);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppg_wc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            state_nxt = ppg_wc_pkg::ST_RADDR;
          end else if (in_finger_on && track_r) begin
            state_nxt = ppg_wc_pkg::ST_BASE;
          end else begin
            state_nxt = ppg_wc_pkg::ST_DONE;
          end
        end
      end
      ppg_wc_pkg::ST_BASE:   state_nxt = ppg_wc_pkg::ST_ACC;
      ppg_wc_pkg::ST_ACC: begin
        state_nxt = acc_emit ? ppg_wc_pkg::ST_PSTART : ppg_wc_pkg::ST_DONE;
      end
      ppg_wc_pkg::ST_PSTART: state_nxt = ppg_wc_pkg::ST_PWAIT;
      ppg_wc_pkg::ST_PWAIT: begin
        if (div_stat.done) begin
          state_nxt = ppg_wc_pkg::ST_PUSH;
        end
      end
      ppg_wc_pkg::ST_PUSH:   state_nxt = ppg_wc_pkg::ST_DONE;
      ppg_wc_pkg::ST_RADDR: begin
        state_nxt = pos_ok ? ppg_wc_pkg::ST_RDATA : ppg_wc_pkg::ST_DONE;
      end
      ppg_wc_pkg::ST_RDATA:  state_nxt = ppg_wc_pkg::ST_RSTART;
      ppg_wc_pkg::ST_RSTART: state_nxt = ppg_wc_pkg::ST_RWAIT;
      ppg_wc_pkg::ST_RWAIT: begin
        if (div_stat.done) begin
          state_nxt = ppg_wc_pkg::ST_RROW;
        end
      end
      ppg_wc_pkg::ST_RROW:   state_nxt = ppg_wc_pkg::ST_DONE;
      ppg_wc_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = ppg_wc_pkg::ST_IDLE;
        end
      end
      default:               state_nxt = ppg_wc_pkg::ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    base_nxt  = base_r;
    wp_nxt    = wp_r;
    vcnt_nxt  = vcnt_r;
    sum_nxt   = sum_r;
    scnt_nxt  = scnt_r;
    phase_nxt = phase_r;
    env_nxt   = env_r;
    track_nxt = track_r;
    cmd_nxt   = cmd_r;
    ir_nxt    = ir_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    rdy_nxt   = rdy_r;
    point_nxt = point_r;
    hrst_nxt  = hrst_r;
    row_nxt   = row_r;
    ok_nxt    = ok_r;
    mem_we    = 1'b0;
    div_start = 1'b0;
    div_dvd   = cmd_r ? DVD_W'(prod_r) : abs_sum;
    div_dvs   = cmd_r ? DVS_W'(row_div) : DVS_W'(scnt_r);
    ovalid_nxt = out_load ? 1'b1 : (ovalid_r && out_stall);
    unique case (state_r)
      ppg_wc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          ir_nxt    = in_ir_sample;
          pos_nxt   = in_position;
          rdy_nxt   = 1'b0;
          point_nxt = '0;
          hrst_nxt  = 1'b0;
          row_nxt   = '0;
          ok_nxt    = 1'b0;
          if (!in_cmd && (!in_finger_on || !track_r)) begin
            // finger lost, or finger back and the baseline is seeded
            if (in_finger_on || track_r || (vcnt_r != '0)) begin
              base_nxt  = in_finger_on ? BASE_W'(in_ir_sample) << FRAC_BITS : '0;
              wp_nxt    = '0;
              vcnt_nxt  = '0;
              sum_nxt   = '0;
              scnt_nxt  = '0;
              phase_nxt = '0;
              env_nxt   = minsc_r;
              track_nxt = in_finger_on;
              hrst_nxt  = 1'b1;
            end
          end
        end
      end
      ppg_wc_pkg::ST_BASE: begin
        base_nxt = bsum[BASE_W-1:0];
      end
      ppg_wc_pkg::ST_ACC: begin
        sum_nxt   = sum_new;
        scnt_nxt  = scnt_new;
        phase_nxt = ph_wrap ? ph_add - pwrap_r : ph_add;
      end
      ppg_wc_pkg::ST_PSTART: begin
        neg_nxt   = sum_r[SUM_W-1];
        div_start = 1'b1;
      end
      ppg_wc_pkg::ST_PWAIT: ;
      ppg_wc_pkg::ST_PUSH: begin
        mem_we    = 1'b1;
        point_nxt = pt_val;
        rdy_nxt   = 1'b1;
        sum_nxt   = '0;
        scnt_nxt  = '0;
        wp_nxt    = (wp_r == LAST_IDX) ? '0 : wp_r + IDX_W'(1);
        if (vcnt_r < FULL_CNT) begin
          vcnt_nxt = vcnt_r + VCNT_W'(1);
        end
        if (qmag > PT_W'(env_r)) begin
          env_nxt = qmag[ENV_W-1:0];
        end else if (env_r > minsc_r) begin
          env_nxt = env_r - ((dec != '0) ? dec : ENV_W'(1));
        end
      end
      ppg_wc_pkg::ST_RADDR: begin
        if (!pos_ok) begin
          row_nxt = center_r;
        end
      end
      ppg_wc_pkg::ST_RDATA: begin
        neg_nxt  = mem_rd[PT_W-1];
        prod_nxt = PROD_W'(rd_mag) * PROD_W'(hh_r);
      end
      ppg_wc_pkg::ST_RSTART: begin
        div_start = 1'b1;
      end
      ppg_wc_pkg::ST_RWAIT: ;
      ppg_wc_pkg::ST_RROW: begin
        row_nxt = y_clip[ROW_W-1:0];
        ok_nxt  = 1'b1;
      end
      ppg_wc_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    ir_r    <= ir_nxt;
    pos_r   <= pos_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    rdy_r   <= rdy_nxt;
    point_r <= point_nxt;
    hrst_r  <= hrst_nxt;
    row_r   <= row_nxt;
    ok_r    <= ok_nxt;
    if (out_load) begin
      out_point_ready   <= rdy_r;
      out_ac_point      <= point_r;
      out_envelope      <= env_r;
      out_stored_count  <= OCW'(vcnt_r);
      out_history_reset <= hrst_r;
      out_pixel_row     <= row_r;
      out_read_ok       <= ok_r;
    end
    if (!rst_n) begin
      state_r  <= ppg_wc_pkg::ST_IDLE;
      base_r   <= '0;
      wp_r     <= '0;
      vcnt_r   <= '0;
      sum_r    <= '0;
      scnt_r   <= '0;
      phase_r  <= '0;
      env_r    <= ppg_wc_pkg::MINSC_RST;
      track_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      wp_r     <= wp_nxt;
      vcnt_r   <= vcnt_nxt;
      sum_r    <= sum_nxt;
      scnt_r   <= scnt_nxt;
      phase_r  <= phase_nxt;
      env_r    <= env_nxt;
      track_r  <= track_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  ppg_wc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  ppg_wc_hist #(
    .POINTS (POINTS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wp_r),
    .wr_data (pt_val),
    .rd_addr (idx_w[IDX_W-1:0]),
    .rd_data (mem_rd)
  );

endmodule

`default_nettype wire

### rtl/core/ppg_wc_chk.sv
// port-level checker for the ppg waveform conditioner, bound to the top level
// depends on ppg_wc_pkg and ppg_waveform_conditioner_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ppg_waveform_conditioner_unit_assert.svh"

module ppg_wc_chk (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    in_valid,
  input wire logic                                    in_stall,
  input wire logic                                    out_valid,
  input wire logic                                    out_stall,
  input wire logic                                    out_point_ready,
  input wire logic        [ppg_wc_pkg::CNT_OUT_W-1:0] out_stored_count,
  input wire logic                                    out_history_reset,
  input wire logic                                    out_read_ok
);

  `PPG_WC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out item dropped while stalled")

  `PPG_WC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")

  `PPG_WC_ASSERT_NOW(a_clear_empty, clk, rst_n, out_valid && out_history_reset, !out_point_ready && out_stored_count == '0, "history clear left points")

  `PPG_WC_ASSERT_NOW(a_read_fields, clk, rst_n, out_valid && out_read_ok, !out_point_ready && !out_history_reset && out_stored_count != '0, "read item shows sample fields")

endmodule

bind ppg_waveform_conditioner_unit ppg_wc_chk u_chk (.*);

`default_nettype wire

### tb/tb.sv
// testbench for ppg_waveform_conditioner_unit: random and directed samples and reads,
// checked against a behavioral predictor of baseline, averaging, envelope and row mapping
// depends on ppg_wc_pkg and the ppg_waveform_conditioner_unit rtl
`timescale 1ns / 1ps

module tb;
  import ppg_wc_pkg::*;

  localparam bit CMD_SAMPLE = 1'b0;
  localparam bit CMD_READ   = 1'b1;
  localparam int HIST_N     = 128;
  localparam int ROW_MIN    = WAVE_TOP_DEF + 1;
  localparam int ROW_MAX    = WAVE_BOTTOM_DEF - 1;

  typedef struct {
    bit           point_ready;
    logic [18:0]  ac_point;
    logic [17:0]  envelope;
    logic [7:0]   stored_count;
    bit           history_reset;
    logic [5:0]   pixel_row;
    bit           read_ok;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [IR_W-1:0] in_ir_sample = '0;
  logic in_finger_on = 1'b0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_point_ready;
  logic signed [PT_W-1:0] out_ac_point;
  logic [ENV_W-1:0] out_envelope;
  logic [CNT_OUT_W-1:0] out_stored_count;
  logic out_history_reset;
  logic [ROW_W-1:0] out_pixel_row;
  logic out_read_ok;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  ppg_waveform_conditioner_unit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor registers and state
  int unsigned r_bshift, r_pstep, r_pwrap, r_dshift, r_center, r_hh;
  longint r_min;
  longint base_q, acc_sum, env;
  int hist [HIST_N];
  int wr_pos, n_pts, acc_cnt, ph;
  bit tracking;

  frame_t pending_q[$];
  int errors = 0;
  bit no_gaps = 0;
  int stall_left = 0;
  int dc_level = 100000;
  int pulse_t = 0;

  function automatic void clear_state();
    wr_pos = 0; n_pts = 0; base_q = 0; acc_sum = 0; acc_cnt = 0; ph = 0;
    env = r_min; tracking = 0;
  endfunction

  function automatic void store_point(longint p);
    longint mag, d;
    mag = p < 0 ? -p : p;
    hist[wr_pos] = int'(p);
    wr_pos = (wr_pos + 1) % HIST_N;
    if (n_pts < HIST_N) n_pts++;
    if (mag > env) env = mag;
    else if (env > r_min) begin
      d = (env - r_min) >>> r_dshift;
      env -= (d > 0) ? d : 1;
    end
  endfunction

  function automatic int row_of(longint p);
    longint dv, s, y, hh;
    hh = r_hh;
    dv = (env >= r_min) ? env : r_min;
    if (dv <= 0) dv = 1;
    s = (p * hh) / dv;
    if (s > hh) s = hh;
    else if (s < -hh) s = -hh;
    y = longint'(r_center) - s;
    if (y < ROW_MIN) y = ROW_MIN;
    else if (y > ROW_MAX) y = ROW_MAX;
    return int'(y);
  endfunction

  function automatic frame_t condition(bit cmd, longint ir, bit finger, int pos);
    frame_t f;
    longint p, ac;
    bit emit;
    f = '{default: 0};
    p = 0;
    if (cmd == CMD_READ) begin
      if (pos < n_pts) begin
        f.pixel_row = 6'(row_of(hist[(wr_pos + HIST_N - n_pts + pos) % HIST_N]));
        f.read_ok = 1;
      end else f.pixel_row = 6'(r_center);
    end else if (!finger) begin
      if (tracking || n_pts != 0) begin
        clear_state();
        f.history_reset = 1;
      end
    end else if (!tracking) begin
      clear_state();
      tracking = 1;
      base_q = ir <<< FRAC_BITS_DEF;
      f.history_reset = 1;
    end else begin
      base_q += ((ir <<< FRAC_BITS_DEF) - base_q) >>> r_bshift;
      ac = ir - (base_q >>> FRAC_BITS_DEF);
      acc_sum += ac;
      acc_cnt++;
      ph = (ph + r_pstep) & 255;
      emit = 0;
      if (ph >= r_pwrap) begin
        ph = (ph - r_pwrap) & 255;
        emit = 1;
      end else if (acc_cnt >= 255) emit = 1;
      if (emit) begin
        p = acc_sum / acc_cnt;
        store_point(p);
        acc_sum = 0;
        acc_cnt = 0;
        f.point_ready = 1;
      end
    end
    f.ac_point = p[18:0];
    f.envelope = env[17:0];
    f.stored_count = n_pts[7:0];
    return f;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // result side: random stall and comparison
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result actual row %0d", $time, out_pixel_row);
        errors++;
      end else begin
        frame_t w;
        w = pending_q.pop_front();
        check_field("point_ready", w.point_ready, out_point_ready);
        check_field("ac_point", w.ac_point, out_ac_point[18:0]);
        check_field("envelope", w.envelope, out_envelope);
        check_field("stored_count", w.stored_count, out_stored_count);
        check_field("history_reset", w.history_reset, out_history_reset);
        check_field("pixel_row", w.pixel_row, out_pixel_row);
        check_field("read_ok", w.read_ok, out_read_ok);
      end
      stall_left = no_gaps ? 0 : $urandom_range(0, 3);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else out_stall <= 1'b0;
  end

  task automatic send_item(bit cmd, int ir, bit finger, int pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_ir_sample <= ir[IR_W-1:0];
    in_finger_on <= finger;
    in_position <= pos[POS_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(condition(cmd, ir, finger, pos));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASELINE_SHIFT: r_bshift = val & 15;
      CFG_PHASE_STEP:     r_pstep = val & 255;
      CFG_PHASE_WRAP:     r_pwrap = val & 255;
      CFG_MIN_SCALE:      r_min = val & 32'h3FFFF;
      CFG_DECAY_SHIFT:    r_dshift = val & 15;
      CFG_WAVE_CENTER:    r_center = val & 63;
      CFG_HALF_HEIGHT:    r_hh = val & 31;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned bs, int unsigned ps, int unsigned pw, int unsigned ms,
                         int unsigned ds, int unsigned wc, int unsigned hh);
    drain();
    write_reg(CFG_BASELINE_SHIFT, bs);
    write_reg(CFG_PHASE_STEP, ps);
    write_reg(CFG_PHASE_WRAP, pw);
    write_reg(CFG_MIN_SCALE, ms);
    write_reg(CFG_DECAY_SHIFT, ds);
    write_reg(CFG_WAVE_CENTER, wc);
    write_reg(CFG_HALF_HEIGHT, hh);
  endtask

  function automatic int next_ir();
    int v;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 262143);
    if ($urandom_range(0, 49) == 0) dc_level = $urandom_range(5000, 257000);
    pulse_t = (pulse_t + 1) % 30;
    v = dc_level + (pulse_t < 10 ? pulse_t * 400 : (30 - pulse_t) * 200)
        + $urandom_range(0, 600) - 300;
    if (v < 0) v = 0;
    if (v > 262143) v = 262143;
    return v;
  endfunction

  task automatic test_directed();
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 262143, 1, 127);
    send_item(CMD_SAMPLE, 262143, 0, 127);
    send_item(CMD_SAMPLE, 0, 1, 0);
    repeat (4) send_item(CMD_SAMPLE, 262143, 1, 0);
    repeat (4) send_item(CMD_SAMPLE, 0, 1, 127);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 2);
    send_item(CMD_READ, 0, 0, 127);
    send_item(CMD_SAMPLE, 5, 0, 0);
    send_item(CMD_SAMPLE, 5, 0, 0);
    send_item(CMD_READ, 0, 1, 0);
    send_item(CMD_SAMPLE, 131072, 1, 0);
    repeat (3) send_item(CMD_SAMPLE, 70000, 1, 0);
    send_item(CMD_READ, 0, 0, 0);
  endtask

  task automatic test_stream(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_READ, $urandom_range(0, 262143), $urandom_range(0, 1),
                  (n_pts > 0 && $urandom_range(0, 4) != 0) ?
                  $urandom_range(0, n_pts - 1) : $urandom_range(0, 127));
      else
        send_item(CMD_SAMPLE, next_ir(), $urandom_range(0, 149) != 0,
                  $urandom_range(0, 127));
    end
    no_gaps = 0;
  endtask

  task automatic test_slow_counter();
    // small step against a large wrap lets the sum counter fill up
    set_all(0, 1, 255, 1, 0, 0, 31);
    send_item(CMD_SAMPLE, 1000, 1, 0);
    for (int i = 0; i < 260; i++) begin
      if (i % 13 == 0) no_gaps = !no_gaps;
      send_item(CMD_SAMPLE, $urandom_range(0, 262143), 1, $urandom_range(0, 127));
    end
    no_gaps = 0;
    send_item(CMD_READ, 0, 1, 0);
    send_item(CMD_READ, 0, 1, 1);
  endtask

  initial begin
    r_bshift = BSHIFT_RST; r_pstep = PSTEP_RST; r_pwrap = PWRAP_RST; r_min = MINSC_RST;
    r_dshift = DSHIFT_RST; r_center = CENTER_RST; r_hh = HH_RST;
    clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stream(80);
    drain();
    test_stream(40);
    set_all(15, 255, 255, 262143, 15, 63, 31);
    test_stream(30);
    set_all(0, 1, 1, 1, 0, 0, 0);
    test_stream(30);
    set_all(3, 70, 90, 2000, 2, 30, 12);
    test_stream(40);
    test_slow_counter();
    set_all(6, 40, 100, 300, 6, 40, 21);
    test_stream(40);
    drain();
    if (errors == 0) $display("PASS ppg_waveform_conditioner_unit");
    else $display("FAIL ppg_waveform_conditioner_unit");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL ppg_waveform_conditioner_unit");
    $finish;
  end

endmodule
